// File: hdl/drl_pkg.sv
// ----------------------------------------------------------------------------
// Run list decoder package
// Shared types and codes for the run list decoder: result status codes,
// decoder phase encoding and the result record passed to the output stage.
// ----------------------------------------------------------------------------
package drl_pkg;

    // Result status codes.
    localparam logic [1:0] ST_RUN    = 2'd0;
    localparam logic [1:0] ST_END    = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;
    localparam logic [1:0] ST_FORMAT = 2'd3;

    // Field widths of a result beat.
    localparam int unsigned VCN_W  = 63;
    localparam int unsigned LCN_W  = 64;

    // Decoder phase, one-hot.
    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_COUNT  = 4'b0010,
        PH_OFFSET = 4'b0100,
        PH_ENDED  = 4'b1000
    } t_phase;

    // One decoded result beat.
    typedef struct packed {
        logic [1:0]              status;
        logic signed [LCN_W-1:0] cluster_number;
        logic                    is_sparse;
        logic [VCN_W-1:0]        cluster_count;
        logic [VCN_W-1:0]        first_virtual;
        logic signed [LCN_W-1:0] last_virtual;
    } t_result;

endpackage

// File: hdl/data_run_list_decoder.sv
// ----------------------------------------------------------------------------
// Data run list decoder
// Decodes an extent run list one byte per beat into run descriptors.
// ----------------------------------------------------------------------------
// The decoder takes one run list byte per clock cycle and gives one result
// beat for each completed run, end of list, or error. A byte is held in an
// input register, decoded there against the running state, and any result
// is written into the output register, where it is presented until it is
// taken. Bytes that make no result keep flowing while a result waits at the
// output; the input stalls only when a byte that makes a result meets a
// full, stalled output register. The limit register may be written whenever
// the list is idle; the write port is always ready.
module data_run_list_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input byte channel.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_run_byte,
    input  logic                          i_list_start,
    // Result channel.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic signed [63:0]            o_cluster_number,
    output logic                          o_is_sparse,
    output logic [62:0]                   o_cluster_count,
    output logic [62:0]                   o_first_virtual,
    output logic signed [63:0]            o_last_virtual,
    // Limit register write channel.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [62:0]                   i_cfg_data
);
    import drl_pkg::*;

    // Limit register, stored as last virtual cluster plus one.
    logic [63:0] r_end_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_limit <= 64'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_end_limit <= {1'b0, i_cfg_data} + 64'd1;
        end
    end

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    // Output register.
    logic    r_out_valid;
    t_result r_out;

    logic    core_has_result;
    t_result core_result;
    logic    out_free;
    logic    proc_go;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc_go    = r_in_valid && (!core_has_result || out_free);
    assign o_in_stall = r_in_valid && !proc_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte  <= i_run_byte;
            r_in_start <= i_list_start;
        end
    end

    // Decode core.
    drl_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (proc_go),
        .i_run_byte   (r_in_byte),
        .i_list_start (r_in_start),
        .i_end_limit  (r_end_limit),
        .o_has_result (core_has_result),
        .o_result     (core_result)
    );

    // Output register update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proc_go && core_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && proc_go && core_has_result) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_cluster_number = r_out.cluster_number;
    assign o_is_sparse      = r_out.is_sparse;
    assign o_cluster_count  = r_out.cluster_count;
    assign o_first_virtual  = r_out.first_virtual;
    assign o_last_virtual   = r_out.last_virtual;

endmodule

// File: hdl/drl_core.sv
// ----------------------------------------------------------------------------
// Run list decoder core
// Holds the running decode state and processes one list byte per enabled
// cycle. Produces at most one result per byte, combinationally, for the
// output register in the top level.
// ----------------------------------------------------------------------------
module drl_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_go,
    input  logic [7:0]              i_run_byte,
    input  logic                    i_list_start,
    input  logic [63:0]             i_end_limit,
    output logic                    o_has_result,
    output drl_pkg::t_result        o_result
);
    import drl_pkg::*;

    // Sign-extends an offset of the given byte width to 64 bits.
    function automatic logic [63:0] sext_offset(input logic [63:0] acc,
                                                input logic [3:0] width);
        logic [63:0] res;
        logic        sign;
        res  = acc;
        sign = 1'b0;
        case (width)
            4'd1:    sign = acc[7];
            4'd2:    sign = acc[15];
            4'd3:    sign = acc[23];
            4'd4:    sign = acc[31];
            4'd5:    sign = acc[39];
            4'd6:    sign = acc[47];
            4'd7:    sign = acc[55];
            default: sign = 1'b0;
        endcase
        for (int k = 0; k < 8; k++) begin
            if (sign && (4'(k) >= width)) begin
                res[8*k +: 8] = 8'hFF;
            end
        end
        return res;
    endfunction

    // State registers.
    t_phase      r_phase;
    logic [3:0]  r_count_width;
    logic [3:0]  r_offset_width;
    logic [3:0]  r_byte_index;
    logic [63:0] r_count_accum;
    logic [63:0] r_offset_accum;
    logic [63:0] r_running;
    logic [63:0] r_next_virtual;
    logic        r_error;

    t_phase      n_phase;
    logic [3:0]  n_count_width;
    logic [3:0]  n_offset_width;
    logic [3:0]  n_byte_index;
    logic [63:0] n_count_accum;
    logic [63:0] n_offset_accum;
    logic [63:0] n_running;
    logic [63:0] n_next_virtual;
    logic        n_error;

    // State as seen by this byte: a list start clears it first.
    t_phase      cur_phase;
    logic [3:0]  cur_count_width;
    logic [3:0]  cur_offset_width;
    logic [3:0]  cur_byte_index;
    logic [63:0] cur_count_accum;
    logic [63:0] cur_offset_accum;
    logic [63:0] cur_running;
    logic [63:0] cur_next_virtual;
    logic        cur_error;

    always_comb begin
        if (i_list_start) begin
            cur_phase        = PH_HEADER;
            cur_count_width  = '0;
            cur_offset_width = '0;
            cur_byte_index   = '0;
            cur_count_accum  = '0;
            cur_offset_accum = '0;
            cur_running      = '0;
            cur_next_virtual = '0;
            cur_error        = 1'b0;
        end else begin
            cur_phase        = r_phase;
            cur_count_width  = r_count_width;
            cur_offset_width = r_offset_width;
            cur_byte_index   = r_byte_index;
            cur_count_accum  = r_count_accum;
            cur_offset_accum = r_offset_accum;
            cur_running      = r_running;
            cur_next_virtual = r_next_virtual;
            cur_error        = r_error;
        end
    end

    // Byte merge, offset extension and end-of-run arithmetic.
    logic [63:0] byte_shifted;
    logic [3:0]  index_inc;
    logic [63:0] count_merged;
    logic [63:0] offset_merged;
    logic [63:0] count_use;
    logic [63:0] offset_use;
    logic [63:0] offset_sx;
    logic [63:0] running_new;
    logic [63:0] run_end;
    logic        run_over;

    assign byte_shifted  = {56'd0, i_run_byte} << {cur_byte_index[2:0], 3'b000};
    assign index_inc     = cur_byte_index + 4'd1;
    assign count_merged  = cur_count_accum | byte_shifted;
    assign offset_merged = cur_offset_accum | byte_shifted;
    assign count_use     = (cur_phase == PH_COUNT) ? count_merged : cur_count_accum;
    assign offset_use    = (cur_phase == PH_OFFSET) ? offset_merged : cur_offset_accum;
    assign offset_sx     = sext_offset(offset_use, cur_offset_width);
    assign running_new   = cur_running + offset_sx;
    assign run_end       = cur_next_virtual + count_use;
    assign run_over      = run_end > i_end_limit;

    // Next state and result for this byte.
    logic    finish;
    logic    fail_format;
    t_result res;

    always_comb begin
        n_phase        = cur_phase;
        n_count_width  = cur_count_width;
        n_offset_width = cur_offset_width;
        n_byte_index   = cur_byte_index;
        n_count_accum  = cur_count_accum;
        n_offset_accum = cur_offset_accum;
        n_running      = cur_running;
        n_next_virtual = cur_next_virtual;
        n_error        = cur_error;
        o_has_result   = 1'b0;
        finish         = 1'b0;
        fail_format    = 1'b0;
        res            = '0;

        if (!cur_error) begin
            case (cur_phase)
                PH_HEADER: begin
                    if (i_run_byte == 8'd0) begin
                        n_phase      = PH_ENDED;
                        o_has_result = 1'b1;
                        res.status   = ST_END;
                    end else begin
                        n_count_width  = i_run_byte[3:0];
                        n_offset_width = i_run_byte[7:4];
                        if ((i_run_byte[3:0] == 4'd0) || (i_run_byte[3:0] > 4'd8) ||
                            (i_run_byte[7:4] > 4'd8)) begin
                            fail_format = 1'b1;
                        end else begin
                            n_count_accum  = '0;
                            n_offset_accum = '0;
                            n_byte_index   = '0;
                            n_phase        = PH_COUNT;
                        end
                    end
                end
                PH_COUNT: begin
                    n_count_accum = count_merged;
                    n_byte_index  = index_inc;
                    if (index_inc >= cur_count_width) begin
                        if (count_merged[63]) begin
                            fail_format = 1'b1;
                        end else begin
                            n_byte_index = '0;
                            if (cur_offset_width == 4'd0) begin
                                finish = 1'b1;
                            end else begin
                                n_phase = PH_OFFSET;
                            end
                        end
                    end
                end
                PH_OFFSET: begin
                    n_offset_accum = offset_merged;
                    n_byte_index   = index_inc;
                    if (index_inc >= cur_offset_width) begin
                        n_byte_index = '0;
                        finish       = 1'b1;
                    end
                end
                default: begin
                    // End of list reached: bytes are dropped until a list start.
                end
            endcase
        end

        // Completed run: update the running cluster and check the range.
        if (finish) begin
            n_running    = running_new;
            n_phase      = PH_HEADER;
            o_has_result = 1'b1;
            if (run_over) begin
                n_error    = 1'b1;
                res.status = ST_RANGE;
            end else begin
                n_next_virtual     = run_end;
                res.status         = ST_RUN;
                res.cluster_number = (offset_sx != 64'd0) ? running_new : '1;
                res.is_sparse      = (offset_sx == 64'd0);
                res.cluster_count  = count_use[VCN_W-1:0];
                res.first_virtual  = cur_next_virtual[VCN_W-1:0];
                res.last_virtual   = run_end - 64'd1;
            end
        end

        if (fail_format) begin
            n_error      = 1'b1;
            n_phase      = PH_HEADER;
            o_has_result = 1'b1;
            res          = '0;
            res.status   = ST_FORMAT;
        end
    end

    assign o_result = res;

    // State update on each processed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEADER;
            r_count_width  <= '0;
            r_offset_width <= '0;
            r_byte_index   <= '0;
            r_count_accum  <= '0;
            r_offset_accum <= '0;
            r_running      <= '0;
            r_next_virtual <= '0;
            r_error        <= 1'b0;
        end else if (i_go) begin
            r_phase        <= n_phase;
            r_count_width  <= n_count_width;
            r_offset_width <= n_offset_width;
            r_byte_index   <= n_byte_index;
            r_count_accum  <= n_count_accum;
            r_offset_accum <= n_offset_accum;
            r_running      <= n_running;
            r_next_virtual <= n_next_virtual;
            r_error        <= n_error;
        end
    end

endmodule
